/* rtl/core/audio_output_shaping_filter_macros.svh */
// Assertion macros shared by the audio output shaping filter modules.
`ifndef AUDIO_OUTPUT_SHAPING_FILTER_MACROS_SVH
`define AUDIO_OUTPUT_SHAPING_FILTER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define AOSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define AOSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/aosf_pkg.sv */
// Shared widths, reset values, codes and control types of the audio output shaping filter.
package aosf_pkg;

  // Field and register widths.
  localparam int SampleW  = 24;
  localparam int OutW     = 16;
  localparam int CoefW    = 16;
  localparam int GainW    = 18;
  localparam int CfgDataW = 18;
  localparam int CfgIdxW  = 2;

  // Datapath widths. The scaled sample is a 24 x 18 bit product.
  localparam int XW     = SampleW + GainW;
  localparam int AccW   = 46;
  localparam int LoW    = 22;
  localparam int MulAW  = AccW - LoW;
  localparam int MulBW  = GainW + 1;
  localparam int ProdW  = MulAW + MulBW;
  localparam int SumW   = ProdW + LoW + 1;
  localparam int SmW    = 40;
  localparam int FracW  = 16;
  localparam int SmShift = 3;

  // Saturation bounds of the output sample.
  localparam int SatHi = 32767;
  localparam int SatLo = -32768;

  // Register reset values.
  localparam logic [CoefW-1:0] FirstCoefRst  = CoefW'(139);
  localparam logic [CoefW-1:0] SecondCoefRst = CoefW'(35);
  localparam logic [GainW-1:0] GainRst       = GainW'(98304);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_COEF,
    CFG_SECOND_COEF,
    CFG_GAIN,
    CFG_LOWPASS_EN
  } cfg_idx_t;

  // Datapath operations, one per sequencer step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_GAIN,
    OP_DIFF1,
    OP_MUL_LO1,
    OP_MUL_HI1,
    OP_UPD1,
    OP_DIFF2,
    OP_MUL_LO2,
    OP_MUL_HI2,
    OP_UPD2,
    OP_SAT,
    OP_FINISH
  } op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_DIFF1,
    ST_MUL_LO1,
    ST_MUL_HI1,
    ST_UPD1,
    ST_DIFF2,
    ST_MUL_LO2,
    ST_MUL_HI2,
    ST_UPD2,
    ST_SAT,
    ST_FINISH
  } state_t;

  typedef logic signed [AccW-1:0] acc_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/core/aosf_in_if.sv */
// Input channel: one signed audio sample word with its buffer end mark.
interface aosf_in_if;
  import aosf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample_in;
  logic                      block_end;

  modport source (output valid, output sample_in, output block_end, input ready);
  modport sink (input valid, input sample_in, input block_end, output ready);
endinterface

/* rtl/core/aosf_out_if.sv */
// Output channel: one filtered 16-bit sample word with its buffer end mark.
interface aosf_out_if;
  import aosf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] sample_out;
  logic                   block_end_out;

  modport source (output valid, output sample_out, output block_end_out, input ready);
  modport sink (input valid, input sample_out, input block_end_out, output ready);
endinterface

/* rtl/core/aosf_datapath.sv */
// Datapath: configuration registers, shared multiplier, accumulators and output register.
`include "audio_output_shaping_filter_macros.svh"

module aosf_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [aosf_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [aosf_pkg::CfgDataW-1:0]      cfg_data,
  input  logic signed [aosf_pkg::SampleW-1:0] sample_in,
  input  logic                               block_end,
  input  aosf_pkg::dp_cmd_t                  cmd,
  output aosf_pkg::dp_sts_t                  sts,
  aosf_out_if.source                         out_ch
);
  import aosf_pkg::*;

  logic [CoefW-1:0] first_coef;
  logic [CoefW-1:0] second_coef;
  logic [GainW-1:0] gain;
  logic             lowpass_en;

  logic signed [SampleW-1:0] s_reg;
  logic                      blk;
  logic signed [XW-1:0]      x;
  acc_t                      d;
  acc_t                      tr;
  acc_t                      res;
  logic signed [ProdW-1:0]   p_lo;
  logic signed [ProdW-1:0]   p_hi;
  logic signed [OutW-1:0]    t;
  logic signed [SmW-1:0]     sm;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [SumW-1:0]  step_sum;
  logic signed [SumW-1:0]  step_shift;
  logic signed [AccW:0]    t_sum;
  logic signed [AccW:0]    t_shift;
  logic signed [OutW-1:0]  t_next;
  logic signed [SmW:0]     sm_diff;
  logic signed [SmW:0]     sm_step;
  logic signed [SmW-1:0]   sm_next;
  logic signed [OutW-1:0]  result;
  logic                    out_valid;
  logic                    out_free;
  logic                    finish;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_coef  <= FirstCoefRst;
      second_coef <= SecondCoefRst;
      gain        <= GainRst;
      lowpass_en  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIRST_COEF:  first_coef  <= cfg_data[CoefW-1:0];
        CFG_SECOND_COEF: second_coef <= cfg_data[CoefW-1:0];
        CFG_GAIN:        gain        <= cfg_data[GainW-1:0];
        CFG_LOWPASS_EN:  lowpass_en  <= cfg_data[0];
      endcase
    end
  end

  // Operand selection for the shared multiplier; wide differences go in two halves.
  always_comb begin
    unique case (cmd.op)
      OP_GAIN: begin
        mul_a = s_reg;
        mul_b = {1'b0, gain};
      end
      OP_MUL_LO1: begin
        mul_a = {{(MulAW-LoW){1'b0}}, d[LoW-1:0]};
        mul_b = {{(MulBW-CoefW){1'b0}}, first_coef};
      end
      OP_MUL_HI1: begin
        mul_a = d[AccW-1:LoW];
        mul_b = {{(MulBW-CoefW){1'b0}}, first_coef};
      end
      OP_MUL_LO2: begin
        mul_a = {{(MulAW-LoW){1'b0}}, d[LoW-1:0]};
        mul_b = {{(MulBW-CoefW){1'b0}}, second_coef};
      end
      OP_MUL_HI2: begin
        mul_a = d[AccW-1:LoW];
        mul_b = {{(MulBW-CoefW){1'b0}}, second_coef};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Recombine the two partial products and drop the 16 fraction bits.
  assign step_sum   = (SumW'(p_hi) <<< LoW) + SumW'(p_lo);
  assign step_shift = step_sum >>> FracW;

  // Output sum, shifted and saturated to 16 bits.
  assign t_sum   = (AccW+1)'(tr) - (AccW+1)'(x) + (AccW+1)'(res);
  assign t_shift = t_sum >>> FracW;

  always_comb begin
    if (t_shift > (AccW+1)'(SatHi)) begin
      t_next = OutW'(SatHi);
    end else if (t_shift < (AccW+1)'(SatLo)) begin
      t_next = OutW'(SatLo);
    end else begin
      t_next = t_shift[OutW-1:0];
    end
  end

  // One-pole smoothing with a step of one eighth.
  assign sm_diff = ((SmW+1)'(t) <<< FracW) - (SmW+1)'(sm);
  assign sm_step = sm_diff >>> SmShift;
  assign sm_next = sm + sm_step[SmW-1:0];
  assign result  = lowpass_en ? sm_next[FracW+OutW-1:FracW] : t;

  assign out_free     = !out_valid || out_ch.ready;
  assign finish       = (cmd.op == OP_FINISH) && out_free;
  assign sts.out_free = out_free;

  // Working registers, loaded by the step that the sequencer selects.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        s_reg <= sample_in;
        blk   <= block_end;
      end
      OP_GAIN:    x    <= mul_p[XW-1:0];
      OP_DIFF1:   d    <= AccW'(x) - tr;
      OP_DIFF2:   d    <= AccW'(x) - tr - res;
      OP_MUL_LO1: p_lo <= mul_p;
      OP_MUL_LO2: p_lo <= mul_p;
      OP_MUL_HI1: p_hi <= mul_p;
      OP_MUL_HI2: p_hi <= mul_p;
      OP_SAT:     t    <= t_next;
      default: ;
    endcase
  end

  // Filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      tr  <= '0;
      res <= '0;
      sm  <= '0;
    end else begin
      if (cmd.op == OP_UPD1) begin
        tr <= tr + step_shift[AccW-1:0];
      end
      if (cmd.op == OP_UPD2) begin
        res <= res + step_shift[AccW-1:0];
      end
      if (finish && lowpass_en) begin
        sm <= sm_next;
      end
    end
  end

  // Output register: the next item may run while this word waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_ch.sample_out    <= result;
      out_ch.block_end_out <= blk;
    end
  end

  assign out_ch.valid = out_valid;

  `AOSF_ASSERT_NEXT(a_finish_loads_word, finish, out_valid, "finished word not presented")
  `AOSF_ASSERT_NEXT(a_smooth_held, !lowpass_en, $stable(sm), "smoothing state moved while off")
  `AOSF_ASSERT_NEXT(a_diff1_value, cmd.op == OP_DIFF1, d == (AccW'($past(x)) - tr), "bad difference")

endmodule

/* rtl/core/aosf_controller.sv */
// Sequencer that steps the datapath through the per-sample operations.
`include "audio_output_shaping_filter_macros.svh"

module aosf_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aosf_pkg::dp_sts_t sts,
  output aosf_pkg::dp_cmd_t cmd
);
  import aosf_pkg::*;

  state_t state;
  state_t state_next;
  logic   in_fire;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd.op     = OP_GAIN;
        state_next = ST_DIFF1;
      end
      ST_DIFF1: begin
        cmd.op     = OP_DIFF1;
        state_next = ST_MUL_LO1;
      end
      ST_MUL_LO1: begin
        cmd.op     = OP_MUL_LO1;
        state_next = ST_MUL_HI1;
      end
      ST_MUL_HI1: begin
        cmd.op     = OP_MUL_HI1;
        state_next = ST_UPD1;
      end
      ST_UPD1: begin
        cmd.op     = OP_UPD1;
        state_next = ST_DIFF2;
      end
      ST_DIFF2: begin
        cmd.op     = OP_DIFF2;
        state_next = ST_MUL_LO2;
      end
      ST_MUL_LO2: begin
        cmd.op     = OP_MUL_LO2;
        state_next = ST_MUL_HI2;
      end
      ST_MUL_HI2: begin
        cmd.op     = OP_MUL_HI2;
        state_next = ST_UPD2;
      end
      ST_UPD2: begin
        cmd.op     = OP_UPD2;
        state_next = ST_SAT;
      end
      ST_SAT: begin
        cmd.op     = OP_SAT;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.op = OP_FINISH;
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `AOSF_ASSERT_NEXT(a_accept_starts, in_fire, state == ST_GAIN, "accepted word did not start")
  `AOSF_ASSERT_NEXT(a_finish_returns, (state == ST_FINISH) && sts.out_free, state == ST_IDLE, "stuck after finish")
  `AOSF_ASSERT_NEXT(a_finish_waits, (state == ST_FINISH) && !sts.out_free, state == ST_FINISH, "result dropped")

endmodule

/* rtl/core/audio_output_shaping_filter.sv */
// An accepted word steps through GAIN, DIFF1, MUL_LO1, MUL_HI1, UPD1, DIFF2, MUL_LO2, MUL_HI2,
// UPD2, SAT and FINISH into the output register; a full output register holds it in FINISH.
// One 24 x 19 multiplier is shared over the gain product and two split coefficient products,
// so a word is accepted only in IDLE, also while the last result waits in the output register.
// Reset (synchronous, active high) restores register defaults, zeroes all accumulators
// and empties the output register.
module audio_output_shaping_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [aosf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [aosf_pkg::CfgDataW-1:0] cfg_data,
  aosf_in_if.sink                       in_ch,
  aosf_out_if.source                    out_ch
);
  import aosf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer.
  aosf_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  aosf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_in (in_ch.sample_in),
    .block_end (in_ch.block_end),
    .cmd       (cmd),
    .sts       (sts),
    .out_ch    (out_ch)
  );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the audio output shaping filter.
`timescale 1ns / 100ps

module testbench;
  import aosf_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_TICKS = 24;
  localparam int PHASES       = 12;
  localparam int PHASE_WORDS  = 160;
  localparam int PRESSURE_AT  = 600;
  localparam int PRESSURE_LEN = 400;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic signed [SampleW-1:0] sample;
    logic                      block_end;
    logic                      typed;
    logic signed [OutW-1:0]    want;
    cfg_idx_t                  reg_idx;
    logic [CfgDataW-1:0]       reg_data;
  } script_row_t;

  typedef struct packed {
    logic signed [OutW-1:0] sample;
    logic                   block_end;
  } out_word_t;

  // Directed script: fixed values only where they follow from reset state and saturation.
  localparam int SCRIPT_LEN = 31;
  localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
    '{ROW_WORD, 24'h000000, 1'b0, 1'b1, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_WORD, 24'h000000, 1'b1, 1'b1, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_WORD, 24'h7FFFFF, 1'b0, 1'b1, 16'h8000, CFG_FIRST_COEF, 18'h0},
    '{ROW_WORD, 24'h800000, 1'b1, 1'b1, 16'h7FFF, CFG_FIRST_COEF, 18'h0},
    '{ROW_WORD, 24'h000001, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_WORD, 24'hFFFFFF, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_WORD, 24'h555555, 1'b1, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_WORD, 24'hAAAAAA, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_CFG,  24'h000000, 1'b0, 1'b0, 16'h0000, CFG_LOWPASS_EN, 18'h1},
    '{ROW_WORD, 24'h7FFFFF, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_WORD, 24'h7FFFFF, 1'b1, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_WORD, 24'h800000, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_WORD, 24'h000000, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_CFG,  24'h000000, 1'b0, 1'b0, 16'h0000, CFG_GAIN,       18'h3FFFF},
    '{ROW_CFG,  24'h000000, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h3FFFF},
    '{ROW_CFG,  24'h000000, 1'b0, 1'b0, 16'h0000, CFG_SECOND_COEF, 18'h3FFFF},
    '{ROW_WORD, 24'h7FFFFF, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_WORD, 24'h800000, 1'b1, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_WORD, 24'h123456, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_CFG,  24'h000000, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_CFG,  24'h000000, 1'b0, 1'b0, 16'h0000, CFG_SECOND_COEF, 18'h0},
    '{ROW_CFG,  24'h000000, 1'b0, 1'b0, 16'h0000, CFG_GAIN,       18'h0},
    '{ROW_WORD, 24'h7FFFFF, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_WORD, 24'h800000, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_CFG,  24'h000000, 1'b0, 1'b0, 16'h0000, CFG_LOWPASS_EN, 18'h3FFFE},
    '{ROW_WORD, 24'h2AAAAA, 1'b1, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_WORD, 24'h000100, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0},
    '{ROW_CFG,  24'h000000, 1'b0, 1'b0, 16'h0000, CFG_GAIN,       18'h10000},
    '{ROW_CFG,  24'h000000, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'd139},
    '{ROW_CFG,  24'h000000, 1'b0, 1'b0, 16'h0000, CFG_SECOND_COEF, 18'd35},
    '{ROW_WORD, 24'h400000, 1'b0, 1'b0, 16'h0000, CFG_FIRST_COEF, 18'h0}
  };

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  aosf_in_if  in_ch ();
  aosf_out_if out_ch ();

  audio_output_shaping_filter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // Shadow registers and filter state of the predictor.
  logic [CoefW-1:0] first_coef_q  = FirstCoefRst;
  logic [CoefW-1:0] second_coef_q = SecondCoefRst;
  logic [GainW-1:0] gain_q        = GainRst;
  logic             lowpass_q     = 1'b0;
  longint           track_acc     = 0;
  longint           resid_acc     = 0;
  longint           smooth_acc    = 0;

  out_word_t expected_words[$];
  int        mismatches    = 0;
  int        words_out     = 0;
  int        hold_left     = 0;
  bit        pressure_done = 1'b0;
  bit        steady_flow   = 1'b0;
  int        cycle_count   = 0;

  // Clock generation; it starts low so that the first rising edge comes after time zero.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Advances the filter by one sample and returns the shaped output sample.
  function automatic logic signed [OutW-1:0] shape_sample(logic signed [SampleW-1:0] s);
    longint x;
    longint sat;
    x = longint'(s) * longint'(gain_q);
    track_acc = track_acc + (((x - track_acc) * longint'(first_coef_q)) >>> 16);
    resid_acc = resid_acc + (((x - track_acc - resid_acc) * longint'(second_coef_q)) >>> 16);
    sat = (track_acc - x + resid_acc) >>> 16;
    if (sat > SatHi) sat = SatHi;
    if (sat < SatLo) sat = SatLo;
    if (lowpass_q) begin
      smooth_acc = smooth_acc + (((sat <<< 16) - smooth_acc) >>> 3);
      sat = smooth_acc >>> 16;
    end
    return sat[OutW-1:0];
  endfunction

  // Sender gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Register value for a random phase: extremes, realistic small values or anything.
  function automatic logic [CfgDataW-1:0] pick_reg_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    if (r < 70) return CfgDataW'($urandom_range(1, 2000));
    return CfgDataW'($urandom);
  endfunction

  // Writes one register and updates the shadow copy.
  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FIRST_COEF:  first_coef_q  = data[CoefW-1:0];
      CFG_SECOND_COEF: second_coef_q = data[CoefW-1:0];
      CFG_GAIN:        gain_q        = data[GainW-1:0];
      CFG_LOWPASS_EN:  lowpass_q     = data[0];
      default: ;
    endcase
  endtask

  // Stops offering words and waits until the block has gone idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Offers one word and records its expected result once it is accepted.
  task automatic send_word(input logic signed [SampleW-1:0] s, input logic be,
                           input logic typed, input logic signed [OutW-1:0] want);
    int        gap;
    out_word_t w;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    in_ch.block_end <= be;
    do @(posedge clk); while (!in_ch.ready);
    w.sample    = shape_sample(s);
    w.block_end = be;
    if (typed) w.sample = want;
    expected_words.push_back(w);
  endtask

  // Output side: checks each word and applies random back-pressure.
  initial begin
    out_word_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (out_ch.valid && out_ch.ready) begin
          words_out = words_out + 1;
          if (expected_words.size() == 0) begin
            $error("sample_out: no word expected, got %0d", $signed(out_ch.sample_out));
            mismatches = mismatches + 1;
          end else begin
            want = expected_words.pop_front();
            if (out_ch.sample_out !== want.sample) begin
              $error("sample_out: expected %0d, got %0d", $signed(want.sample),
                     $signed(out_ch.sample_out));
              mismatches = mismatches + 1;
            end
            if (out_ch.block_end_out !== want.block_end) begin
              $error("block_end_out: expected %0d, got %0d", want.block_end,
                     out_ch.block_end_out);
              mismatches = mismatches + 1;
            end
          end
        end
        // One long hold-off so that the block fills up and stalls its input.
        if (words_out >= PRESSURE_AT && !pressure_done) begin
          pressure_done = 1'b1;
          hold_left     = PRESSURE_LEN;
        end
        if (hold_left > 0) begin
          hold_left = hold_left - 1;
          out_ch.ready <= 1'b0;
        end else if (steady_flow || $urandom_range(0, 99) < 80) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          hold_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 3);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    int                        run_left;
    int                        run_kind;
    int                        lvl_i;
    logic signed [SampleW-1:0] level;
    logic signed [SampleW-1:0] s;
    logic                      toggle;
    run_left = 0;
    run_kind = 0;
    level    = '0;
    toggle   = 1'b0;

    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_FIRST_COEF;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.sample_in <= '0;
    in_ch.block_end <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, starting from the reset configuration.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        settle();
        write_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_data);
      end else begin
        send_word(SCRIPT[i].sample, SCRIPT[i].block_end, SCRIPT[i].typed, SCRIPT[i].want);
      end
    end

    // Random phases, each with its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 0) begin
        write_reg(CFG_FIRST_COEF, '1);
        write_reg(CFG_SECOND_COEF, '1);
        write_reg(CFG_GAIN, '1);
        write_reg(CFG_LOWPASS_EN, '1);
      end else if (p == 1) begin
        write_reg(CFG_FIRST_COEF, '0);
        write_reg(CFG_SECOND_COEF, '0);
        write_reg(CFG_GAIN, '0);
        write_reg(CFG_LOWPASS_EN, '0);
      end else begin
        write_reg(CFG_FIRST_COEF, pick_reg_value());
        write_reg(CFG_SECOND_COEF, pick_reg_value());
        write_reg(CFG_GAIN, ($urandom_range(0, 3) == 0) ? pick_reg_value()
                                                         : CfgDataW'($urandom));
        write_reg(CFG_LOWPASS_EN, CfgDataW'($urandom));
      end
      steady_flow = (p % 4 == 2);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Runs of related samples: steps, noise, small wiggles, extremes, square waves.
        if (run_left == 0) begin
          run_kind = $urandom_range(0, 9);
          run_left = $urandom_range(1, 48);
          level    = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 24'h7FFFFF
                                                                        : 24'h800000)
                                                  : SampleW'($urandom);
        end
        run_left = run_left - 1;
        toggle   = ~toggle;
        case (run_kind)
          4, 5, 6: s = SampleW'($urandom);
          7: begin
            lvl_i = int'(level) + $urandom_range(0, 511) - 256;
            s = SampleW'(lvl_i);
          end
          8: s = toggle ? 24'h7FFFFF : 24'h800000;
          9: s = toggle ? level : -level;
          default: s = level;
        endcase
        send_word(s, ($urandom_range(0, 15) == 0), 1'b0, '0);
      end
    end
    steady_flow = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* audio_output_shaping_filter.f */
+incdir+rtl/core
rtl/core/aosf_pkg.sv
rtl/core/aosf_in_if.sv
rtl/core/aosf_out_if.sv
rtl/core/aosf_datapath.sv
rtl/core/aosf_controller.sv
rtl/core/audio_output_shaping_filter.sv
tb/testbench.sv
